[rtl/tacs_pkg.sv]
// ----------------------------------------------------------------------------
// tacs_pkg
// Shared types, codes and helpers for the type A cascade select sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package tacs_pkg;

	localparam int unsigned MAX_ATTEMPTS = 3;

	localparam logic [7:0] CASCADE_TAG = 8'h88;
	localparam logic [7:0] NVB_ANTI    = 8'h20;
	localparam logic [7:0] NVB_SEL     = 8'h70;
	localparam logic [7:0] SEL_BASE    = 8'h93;
	localparam int unsigned SAK_CASCADE_BIT = 2;
	localparam int unsigned SAK_ISO4_BIT    = 5;

	localparam logic [2:0] ANTI_TX_LEN = 3'd2;
	localparam logic [2:0] SEL_TX_LEN  = 3'd7;
	localparam logic [2:0] ANTI_RX_LEN = 3'd5;
	localparam logic [2:0] SEL_RX_LEN  = 3'd1;

	localparam logic CFG_TAG_MODE  = 1'b0;
	localparam logic CFG_TAG_VALUE = 1'b1;

	localparam logic KIND_START   = 1'b0;
	localparam logic KIND_OUTCOME = 1'b1;

	localparam logic [1:0] RX_OK      = 2'd0;
	localparam logic [1:0] RX_TIMEOUT = 2'd1;

	localparam logic [7:0] TAG_MODE_REJECT = 8'd0;
	localparam logic [7:0] TAG_MODE_VALUE  = 8'd1;

	typedef enum logic [1:0] {
		ACT_SEND    = 2'd0,
		ACT_DONE    = 2'd1,
		ACT_FAIL    = 2'd2,
		ACT_IGNORED = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ERR_NONE    = 3'd0,
		ERR_UID_LEN = 3'd1,
		ERR_COUNT   = 3'd2,
		ERR_BCC     = 3'd3,
		ERR_SELECT  = 3'd4,
		ERR_TAG     = 3'd5,
		ERR_TIMEOUT = 3'd6,
		ERR_COMM    = 3'd7
	} error_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_ANTI = 2'd1,
		PH_SAK  = 2'd2
	} phase_t;

	typedef struct packed {
		logic        kind;
		logic [3:0]  uid_length;
		logic [1:0]  rx_status;
		logic [2:0]  rx_count;
		logic [39:0] rx_data;
	} item_t;

	typedef struct packed {
		action_t     action;
		logic [55:0] tx_frame;
		logic [2:0]  tx_length;
		logic        crc_on;
		logic [2:0]  expected_count;
		error_t      error_code;
		logic [7:0]  sak_byte;
		logic [31:0] uid_part;
		logic [2:0]  uid_part_count;
		logic [1:0]  cascade_level;
		logic        iso4_compliant;
	} result_t;

	typedef struct packed {
		phase_t      phase;
		logic [1:0]  level;
		logic [3:0]  uid_bytes_left;
		logic [1:0]  attempts_used;
		logic [31:0] held_uid_bytes;
		logic [55:0] last_frame;
	} state_t;

	typedef struct packed {
		logic [7:0] tag_check_mode;
		logic [7:0] tag_check_value;
	} cfg_t;

	localparam state_t STATE_IDLE = '{
		phase: PH_IDLE, level: 2'd0, uid_bytes_left: 4'd0, attempts_used: 2'd0,
		held_uid_bytes: 32'd0, last_frame: 56'd0
	};

	function automatic logic [7:0] xor4(input logic [31:0] v);
		return v[7:0] ^ v[15:8] ^ v[23:16] ^ v[31:24];
	endfunction

	function automatic logic [7:0] sel_code(input logic [1:0] level);
		logic [1:0] idx;
		idx = level - 2'd1;
		return SEL_BASE + {5'd0, idx, 1'b0};
	endfunction

endpackage

`default_nettype wire

[rtl/typea_anticollision_select.sv]
// ----------------------------------------------------------------------------
// typea_anticollision_select
// Reader-side cascade anticollision and select sequencer for type A cards.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  in        in_valid / in_stall    kind, uid_length, rx_status, rx_count, rx_data
//  out       out_valid / out_stall  action .. iso4_compliant
//  cfg       cfg_we                 cfg_index, cfg_data
//
//  every word gives one result word, via the input register and the result register
//  one word per cycle sustained while not stalled; the state register is
//  updated in the cycle the input register moves into the result register
//  the input register holds while the result register is full and stalled
//  reset returns the sequencer to idle and clears both tag check registers
// ----------------------------------------------------------------------------
`default_nettype none

module typea_anticollision_select (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire         cfg_index,
	input  wire  [7:0]  cfg_data,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire         kind,
	input  wire  [3:0]  uid_length,
	input  wire  [1:0]  rx_status,
	input  wire  [2:0]  rx_count,
	input  wire  [39:0] rx_data,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [1:0]  action,
	output logic [55:0] tx_frame,
	output logic [2:0]  tx_length,
	output logic        crc_on,
	output logic [2:0]  expected_count,
	output logic [2:0]  error_code,
	output logic [7:0]  sak_byte,
	output logic [31:0] uid_part,
	output logic [2:0]  uid_part_count,
	output logic [1:0]  cascade_level,
	output logic        iso4_compliant
);

	tacs_pkg::item_t   item_s1;
	logic              valid_s1;
	tacs_pkg::state_t  state_q;
	tacs_pkg::state_t  state_nxt;
	tacs_pkg::cfg_t    cfg_q;
	tacs_pkg::result_t res;
	tacs_pkg::result_t res_q;
	logic              advance;
	logic              in_take;

	assign advance = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && out_valid && out_stall;
	assign in_take = in_valid && !in_stall;

	tacs_step u_step (
		.item (item_s1),
		.st   (state_q),
		.cfg  (cfg_q),
		.nxt  (state_nxt),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == tacs_pkg::CFG_TAG_MODE) begin
				cfg_q.tag_check_mode <= cfg_data;
			end else begin
				cfg_q.tag_check_value <= cfg_data;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= '{kind: kind, uid_length: uid_length, rx_status: rx_status,
				rx_count: rx_count, rx_data: rx_data};
		end
	end

	// sequencer state and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tacs_pkg::STATE_IDLE;
			out_valid <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign action = res_q.action;
	assign tx_frame = res_q.tx_frame;
	assign tx_length = res_q.tx_length;
	assign crc_on = res_q.crc_on;
	assign expected_count = res_q.expected_count;
	assign error_code = res_q.error_code;
	assign sak_byte = res_q.sak_byte;
	assign uid_part = res_q.uid_part;
	assign uid_part_count = res_q.uid_part_count;
	assign cascade_level = res_q.cascade_level;
	assign iso4_compliant = res_q.iso4_compliant;

endmodule

`default_nettype wire

[rtl/tacs_step.sv]
// ----------------------------------------------------------------------------
// tacs_step
// Next-state and result logic for one word of the select sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module tacs_step (
	input  var tacs_pkg::item_t   item,
	input  var tacs_pkg::state_t  st,
	input  var tacs_pkg::cfg_t    cfg,
	output tacs_pkg::state_t      nxt,
	output tacs_pkg::result_t     res
);

	function automatic tacs_pkg::result_t emit(input tacs_pkg::state_t s);
		tacs_pkg::result_t r;
		r = '0;
		r.action = tacs_pkg::ACT_SEND;
		r.tx_frame = s.last_frame;
		r.cascade_level = s.level;
		if (s.phase == tacs_pkg::PH_ANTI) begin
			r.tx_length = tacs_pkg::ANTI_TX_LEN;
			r.crc_on = 1'b0;
			r.expected_count = tacs_pkg::ANTI_RX_LEN;
		end else begin
			r.tx_length = tacs_pkg::SEL_TX_LEN;
			r.crc_on = 1'b1;
			r.expected_count = tacs_pkg::SEL_RX_LEN;
			if (s.uid_bytes_left == 4'd0) begin
				r.uid_part = s.held_uid_bytes;
				r.uid_part_count = 3'd4;
			end else begin
				r.uid_part = {8'd0, s.held_uid_bytes[31:8]};
				r.uid_part_count = 3'd3;
			end
		end
		return r;
	endfunction

	function automatic tacs_pkg::state_t to_anti(input tacs_pkg::state_t s);
		tacs_pkg::state_t n;
		n = s;
		n.phase = tacs_pkg::PH_ANTI;
		n.attempts_used = 2'd0;
		n.last_frame = {40'd0, tacs_pkg::NVB_ANTI, tacs_pkg::sel_code(s.level)};
		return n;
	endfunction

	function automatic tacs_pkg::state_t to_select(input tacs_pkg::state_t s);
		tacs_pkg::state_t n;
		n = s;
		n.phase = tacs_pkg::PH_SAK;
		n.attempts_used = 2'd0;
		n.last_frame = {tacs_pkg::xor4(s.held_uid_bytes), s.held_uid_bytes,
			tacs_pkg::NVB_SEL, tacs_pkg::sel_code(s.level)};
		return n;
	endfunction

	logic        len_ok;
	logic        tag_rejected;
	logic        timeout_spent;
	logic [7:0]  b0;
	logic [31:0] four;
	logic [7:0]  bcc;
	logic [7:0]  sak;
	tacs_pkg::state_t tmp;

	assign len_ok = (item.uid_length == 4'd4) || (item.uid_length == 4'd7) ||
		(item.uid_length == 4'd10);
	assign tag_rejected = (cfg.tag_check_mode == tacs_pkg::TAG_MODE_REJECT) ||
		((cfg.tag_check_mode == tacs_pkg::TAG_MODE_VALUE) && (cfg.tag_check_value == 8'd0));
	assign timeout_spent = ({1'b0, st.attempts_used} + 3'd1) >= 3'(tacs_pkg::MAX_ATTEMPTS);
	assign b0 = item.rx_data[7:0];
	assign four = item.rx_data[31:0];
	assign bcc = item.rx_data[39:32];
	assign sak = item.rx_data[7:0];

	always_comb begin
		res = '0;
		nxt = st;
		tmp = st;
		if (item.kind == tacs_pkg::KIND_START) begin
			if (!len_ok) begin
				nxt = tacs_pkg::STATE_IDLE;
				res.action = tacs_pkg::ACT_FAIL;
				res.error_code = tacs_pkg::ERR_UID_LEN;
			end else begin
				tmp = tacs_pkg::STATE_IDLE;
				tmp.level = 2'd1;
				tmp.uid_bytes_left = item.uid_length;
				nxt = to_anti(tmp);
				res = emit(nxt);
			end
		end else if (st.phase == tacs_pkg::PH_IDLE) begin
			res.action = tacs_pkg::ACT_IGNORED;
		end else if (item.rx_status == tacs_pkg::RX_TIMEOUT) begin
			if (timeout_spent) begin
				nxt = tacs_pkg::STATE_IDLE;
				res.action = tacs_pkg::ACT_FAIL;
				res.error_code = tacs_pkg::ERR_TIMEOUT;
				res.cascade_level = st.level;
			end else begin
				nxt.attempts_used = st.attempts_used + 2'd1;
				res = emit(st);
			end
		end else if (item.rx_status != tacs_pkg::RX_OK) begin
			nxt = tacs_pkg::STATE_IDLE;
			res.action = tacs_pkg::ACT_FAIL;
			res.error_code = tacs_pkg::ERR_COMM;
			res.cascade_level = st.level;
		end else if (st.phase == tacs_pkg::PH_ANTI) begin
			res.action = tacs_pkg::ACT_FAIL;
			res.cascade_level = st.level;
			nxt = tacs_pkg::STATE_IDLE;
			if (item.rx_count != tacs_pkg::ANTI_RX_LEN) begin
				res.error_code = tacs_pkg::ERR_COUNT;
			end else if ((tacs_pkg::xor4(four) ^ bcc) != 8'd0) begin
				res.error_code = tacs_pkg::ERR_BCC;
			end else if (st.uid_bytes_left <= 4'd4) begin
				if ((b0 == tacs_pkg::CASCADE_TAG) && tag_rejected) begin
					res.error_code = tacs_pkg::ERR_SELECT;
				end else begin
					tmp.held_uid_bytes = four;
					tmp.uid_bytes_left = 4'd0;
					nxt = to_select(tmp);
					res = emit(nxt);
				end
			end else begin
				if (b0 != tacs_pkg::CASCADE_TAG) begin
					res.error_code = tacs_pkg::ERR_TAG;
				end else begin
					tmp.held_uid_bytes = four;
					tmp.uid_bytes_left = st.uid_bytes_left - 4'd3;
					nxt = to_select(tmp);
					res = emit(nxt);
				end
			end
		end else begin
			res.cascade_level = st.level;
			nxt = tacs_pkg::STATE_IDLE;
			if (item.rx_count != tacs_pkg::SEL_RX_LEN) begin
				res.action = tacs_pkg::ACT_FAIL;
				res.error_code = tacs_pkg::ERR_COUNT;
			end else if (st.uid_bytes_left == 4'd0) begin
				res.sak_byte = sak;
				if (sak[tacs_pkg::SAK_CASCADE_BIT]) begin
					res.action = tacs_pkg::ACT_FAIL;
					res.error_code = tacs_pkg::ERR_SELECT;
				end else begin
					res.action = tacs_pkg::ACT_DONE;
					res.iso4_compliant = sak[tacs_pkg::SAK_ISO4_BIT];
				end
			end else if (!sak[tacs_pkg::SAK_CASCADE_BIT] || (st.level >= 2'd3)) begin
				res.action = tacs_pkg::ACT_FAIL;
				res.error_code = tacs_pkg::ERR_SELECT;
				res.sak_byte = sak;
			end else begin
				tmp.level = st.level + 2'd1;
				nxt = to_anti(tmp);
				res = emit(nxt);
				res.sak_byte = sak;
			end
		end
	end

endmodule

`default_nettype wire

[bench/tb_typea_anticollision_select.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_typea_anticollision_select
// Self-checking bench for the type A cascade select sequencer. A driver feeds
// start and transceiver-outcome words from a queue, and a monitor checks
// every result word against a cycle-free model of the sequencer. The run
// covers directed corner cases, then card sessions for 4, 7 and 10 byte UIDs
// with random content, timeouts and broken replies. Several tag check
// settings are used, with random idling on both sides and one long receiver
// hold-off.
// ----------------------------------------------------------------------------

module tb_typea_anticollision_select;

	localparam int unsigned RUN_LIMIT = 200000;
	localparam logic [1:0] RX_ERROR    = 2'd2;
	localparam logic [1:0] RX_RESERVED = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [7:0]  cfg_data = 8'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        kind = 1'b0;
	logic [3:0]  uid_length = 4'd0;
	logic [1:0]  rx_status = 2'd0;
	logic [2:0]  rx_count = 3'd0;
	logic [39:0] rx_data = 40'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  action;
	logic [55:0] tx_frame;
	logic [2:0]  tx_length;
	logic        crc_on;
	logic [2:0]  expected_count;
	logic [2:0]  error_code;
	logic [7:0]  sak_byte;
	logic [31:0] uid_part;
	logic [2:0]  uid_part_count;
	logic [1:0]  cascade_level;
	logic        iso4_compliant;

	typea_anticollision_select dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .uid_length(uid_length), .rx_status(rx_status),
		.rx_count(rx_count), .rx_data(rx_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.action(action), .tx_frame(tx_frame), .tx_length(tx_length), .crc_on(crc_on),
		.expected_count(expected_count), .error_code(error_code), .sak_byte(sak_byte),
		.uid_part(uid_part), .uid_part_count(uid_part_count),
		.cascade_level(cascade_level), .iso4_compliant(iso4_compliant)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	tacs_pkg::item_t   pending_words[$];
	tacs_pkg::result_t results_due[$];
	int unsigned words_queued = 0;
	int unsigned words_accepted = 0;
	int unsigned faults = 0;
	int unsigned cycles_run = 0;
	int          sender_idle_pct = 32;
	int          receiver_idle_pct = 84;
	logic        hold_wanted = 1'b0;
	logic        hold_given = 1'b0;
	int unsigned hold_left = 0;
	logic        in_taken = 1'b0;

	// sequencer model state and its copy of the tag check registers
	tacs_pkg::phase_t ph = tacs_pkg::PH_IDLE;
	logic [1:0]  seq_level = 2'd0;
	logic [3:0]  uid_left = 4'd0;
	logic [1:0]  timeouts_used = 2'd0;
	logic [31:0] held_uid = 32'd0;
	logic [55:0] frame_sent = 56'd0;
	logic [7:0]  tag_mode = 8'd0;
	logic [7:0]  tag_value = 8'd0;

	function automatic logic [7:0] bcc_of(input logic [31:0] v);
		logic [7:0] acc;
		acc = 8'd0;
		for (int i = 0; i < 4; i++)
			acc = acc ^ v[8*i +: 8];
		return acc;
	endfunction

	function automatic logic [7:0] sel_byte();
		logic [1:0] step;
		step = seq_level - 2'd1;
		return tacs_pkg::SEL_BASE + 8'(step) * 8'd2;
	endfunction

	function automatic void clear_seq();
		ph = tacs_pkg::PH_IDLE;
		seq_level = 2'd0;
		uid_left = 4'd0;
		timeouts_used = 2'd0;
		held_uid = 32'd0;
		frame_sent = 56'd0;
	endfunction

	function automatic tacs_pkg::result_t frame_word();
		tacs_pkg::result_t r;
		r = '0;
		r.action = tacs_pkg::ACT_SEND;
		r.tx_frame = frame_sent;
		r.cascade_level = seq_level;
		if (ph == tacs_pkg::PH_ANTI) begin
			r.tx_length = tacs_pkg::ANTI_TX_LEN;
			r.expected_count = tacs_pkg::ANTI_RX_LEN;
		end else begin
			r.tx_length = tacs_pkg::SEL_TX_LEN;
			r.crc_on = 1'b1;
			r.expected_count = tacs_pkg::SEL_RX_LEN;
			if (uid_left == 4'd0) begin
				r.uid_part = held_uid;
				r.uid_part_count = 3'd4;
			end else begin
				r.uid_part = held_uid >> 8;
				r.uid_part_count = 3'd3;
			end
		end
		return r;
	endfunction

	function automatic tacs_pkg::result_t open_anticoll();
		ph = tacs_pkg::PH_ANTI;
		timeouts_used = 2'd0;
		frame_sent = {40'd0, tacs_pkg::NVB_ANTI, sel_byte()};
		return frame_word();
	endfunction

	function automatic tacs_pkg::result_t open_select();
		ph = tacs_pkg::PH_SAK;
		timeouts_used = 2'd0;
		frame_sent = {bcc_of(held_uid), held_uid, tacs_pkg::NVB_SEL, sel_byte()};
		return frame_word();
	endfunction

	function automatic tacs_pkg::result_t fail_with(input tacs_pkg::error_t code);
		tacs_pkg::result_t r;
		r = '0;
		r.action = tacs_pkg::ACT_FAIL;
		r.error_code = code;
		r.cascade_level = seq_level;
		clear_seq();
		return r;
	endfunction

	function automatic tacs_pkg::result_t predict_word(input tacs_pkg::item_t w);
		tacs_pkg::result_t r;
		logic [31:0] four;
		logic [7:0]  sak;
		logic        tag_refused;
		r = '0;
		four = w.rx_data[31:0];
		sak = w.rx_data[7:0];
		tag_refused = (tag_mode == tacs_pkg::TAG_MODE_REJECT) ||
			(tag_mode == tacs_pkg::TAG_MODE_VALUE && tag_value == 8'd0);
		if (w.kind == tacs_pkg::KIND_START) begin
			clear_seq();
			if (w.uid_length != 4'd4 && w.uid_length != 4'd7 &&
				w.uid_length != 4'd10) begin
				r = fail_with(tacs_pkg::ERR_UID_LEN);
			end else begin
				seq_level = 2'd1;
				uid_left = w.uid_length;
				r = open_anticoll();
			end
		end else if (ph == tacs_pkg::PH_IDLE) begin
			r.action = tacs_pkg::ACT_IGNORED;
		end else if (w.rx_status == tacs_pkg::RX_TIMEOUT) begin
			if (int'(timeouts_used) + 1 >= int'(tacs_pkg::MAX_ATTEMPTS)) begin
				r = fail_with(tacs_pkg::ERR_TIMEOUT);
			end else begin
				timeouts_used = timeouts_used + 2'd1;
				r = frame_word();
			end
		end else if (w.rx_status != tacs_pkg::RX_OK) begin
			r = fail_with(tacs_pkg::ERR_COMM);
		end else if (ph == tacs_pkg::PH_ANTI) begin
			if (w.rx_count != tacs_pkg::ANTI_RX_LEN)
				r = fail_with(tacs_pkg::ERR_COUNT);
			else if (bcc_of(four) != w.rx_data[39:32])
				r = fail_with(tacs_pkg::ERR_BCC);
			else if (uid_left <= 4'd4) begin
				if (four[7:0] == tacs_pkg::CASCADE_TAG && tag_refused) begin
					r = fail_with(tacs_pkg::ERR_SELECT);
				end else begin
					held_uid = four;
					uid_left = 4'd0;
					r = open_select();
				end
			end else if (four[7:0] != tacs_pkg::CASCADE_TAG) begin
				r = fail_with(tacs_pkg::ERR_TAG);
			end else begin
				held_uid = four;
				uid_left = uid_left - 4'd3;
				r = open_select();
			end
		end else begin
			if (w.rx_count != tacs_pkg::SEL_RX_LEN) begin
				r = fail_with(tacs_pkg::ERR_COUNT);
			end else if (uid_left == 4'd0) begin
				if (sak[tacs_pkg::SAK_CASCADE_BIT]) begin
					r = fail_with(tacs_pkg::ERR_SELECT);
					r.sak_byte = sak;
				end else begin
					r.action = tacs_pkg::ACT_DONE;
					r.sak_byte = sak;
					r.cascade_level = seq_level;
					r.iso4_compliant = sak[tacs_pkg::SAK_ISO4_BIT];
					clear_seq();
				end
			end else if (!sak[tacs_pkg::SAK_CASCADE_BIT] || seq_level >= 2'd3) begin
				r = fail_with(tacs_pkg::ERR_SELECT);
				r.sak_byte = sak;
			end else begin
				seq_level = seq_level + 2'd1;
				r = open_anticoll();
				r.sak_byte = sak;
			end
		end
		return r;
	endfunction

	function automatic string field_diffs(input tacs_pkg::result_t w,
		input tacs_pkg::result_t g);
		string s;
		s = "";
		if (g.action !== w.action)
			s = {s, $sformatf(" action %0d/%0d", w.action, g.action)};
		if (g.tx_frame !== w.tx_frame)
			s = {s, $sformatf(" tx_frame %h/%h", w.tx_frame, g.tx_frame)};
		if (g.tx_length !== w.tx_length)
			s = {s, $sformatf(" tx_length %0d/%0d", w.tx_length, g.tx_length)};
		if (g.crc_on !== w.crc_on)
			s = {s, $sformatf(" crc_on %0d/%0d", w.crc_on, g.crc_on)};
		if (g.expected_count !== w.expected_count)
			s = {s, $sformatf(" expected_count %0d/%0d", w.expected_count, g.expected_count)};
		if (g.error_code !== w.error_code)
			s = {s, $sformatf(" error_code %0d/%0d", w.error_code, g.error_code)};
		if (g.sak_byte !== w.sak_byte)
			s = {s, $sformatf(" sak_byte %h/%h", w.sak_byte, g.sak_byte)};
		if (g.uid_part !== w.uid_part)
			s = {s, $sformatf(" uid_part %h/%h", w.uid_part, g.uid_part)};
		if (g.uid_part_count !== w.uid_part_count)
			s = {s, $sformatf(" uid_part_count %0d/%0d", w.uid_part_count, g.uid_part_count)};
		if (g.cascade_level !== w.cascade_level)
			s = {s, $sformatf(" cascade_level %0d/%0d", w.cascade_level, g.cascade_level)};
		if (g.iso4_compliant !== w.iso4_compliant)
			s = {s, $sformatf(" iso4_compliant %0d/%0d", w.iso4_compliant, g.iso4_compliant)};
		return s;
	endfunction

	task automatic note_fault(input string msg);
		faults++;
		if (faults <= 10)
			$display("%s", msg);
	endtask

	function automatic logic [39:0] rand40();
		return {8'($urandom), 32'($urandom)};
	endfunction

	task automatic push_word(input tacs_pkg::item_t w);
		pending_words.push_back(w);
		words_queued++;
	endtask

	task automatic add_start(input logic [3:0] len);
		tacs_pkg::item_t w;
		w.kind = tacs_pkg::KIND_START;
		w.uid_length = len;
		w.rx_status = 2'($urandom);
		w.rx_count = 3'($urandom);
		w.rx_data = rand40();
		push_word(w);
	endtask

	task automatic add_outcome(input logic [1:0] st, input logic [2:0] cnt,
		input logic [39:0] d);
		tacs_pkg::item_t w;
		w.kind = tacs_pkg::KIND_OUTCOME;
		w.uid_length = 4'($urandom);
		w.rx_status = st;
		w.rx_count = cnt;
		w.rx_data = d;
		push_word(w);
	endtask

	task automatic add_reply(input logic [31:0] four);
		add_outcome(tacs_pkg::RX_OK, tacs_pkg::ANTI_RX_LEN, {bcc_of(four), four});
	endtask

	task automatic add_noise();
		tacs_pkg::item_t w;
		logic [63:0]     raw;
		raw = {$urandom, $urandom};
		w = raw[$bits(tacs_pkg::item_t)-1:0];
		w.rx_data = rand40();
		push_word(w);
	endtask

	// a few timeouts before a reply, now and then enough to end the session
	task automatic add_timeouts(output logic gave_up);
		int pick, n;
		pick = $urandom_range(0, 19);
		n = (pick < 12) ? 0 : (pick < 16) ? 1 : (pick < 19) ? 2 : 3;
		for (int i = 0; i < n; i++)
			add_outcome(tacs_pkg::RX_TIMEOUT, 3'($urandom), rand40());
		gave_up = (n == 3);
	endtask

	// now and then a broken reply, or an abort by a fresh start
	task automatic add_spoiler(output logic spoilt);
		spoilt = ($urandom_range(0, 99) < 5);
		if (spoilt) begin
			case ($urandom_range(0, 5))
				0: add_outcome(tacs_pkg::RX_OK, 3'($urandom), rand40());
				1: add_outcome(2'($urandom_range(RX_ERROR, RX_RESERVED)), 3'($urandom),
					rand40());
				2: add_outcome(tacs_pkg::RX_OK, tacs_pkg::ANTI_RX_LEN, rand40());
				3: add_outcome(tacs_pkg::RX_OK, tacs_pkg::SEL_RX_LEN, rand40());
				4: ;
				default: add_noise();
			endcase
		end
	endtask

	task automatic add_session();
		logic [3:0]  len;
		int          left;
		logic        last_level, stop;
		logic [31:0] four;
		logic [7:0]  sak;
		case ($urandom_range(0, 2))
			0: len = 4'd4;
			1: len = 4'd7;
			default: len = 4'd10;
		endcase
		add_start(len);
		left = int'(len);
		while (1) begin
			last_level = (left <= 4);
			add_timeouts(stop);
			if (stop) return;
			add_spoiler(stop);
			if (stop) return;
			four = $urandom;
			if (!last_level || $urandom_range(0, 3) == 0)
				four[7:0] = tacs_pkg::CASCADE_TAG;
			add_reply(four);
			add_timeouts(stop);
			if (stop) return;
			add_spoiler(stop);
			if (stop) return;
			sak = 8'($urandom);
			sak[tacs_pkg::SAK_CASCADE_BIT] = !last_level;
			add_outcome(tacs_pkg::RX_OK, tacs_pkg::SEL_RX_LEN, {32'($urandom), sak});
			if (last_level) return;
			left = left - 3;
		end
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == tacs_pkg::CFG_TAG_MODE)
			tag_mode = val;
		else
			tag_value = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		while (words_accepted != words_queued || results_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// driver
	always @(negedge clk) begin
		tacs_pkg::item_t nxt;
		logic            go;
		if (!in_valid || in_taken) begin
			go = 1'b0;
			if (pending_words.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
				nxt = pending_words.pop_front();
				go = 1'b1;
			end
			in_valid <= go;
			if (go) begin
				kind <= nxt.kind;
				uid_length <= nxt.uid_length;
				rx_status <= nxt.rx_status;
				rx_count <= nxt.rx_count;
				rx_data <= nxt.rx_data;
			end
		end
	end

	// receiver, with one long hold-off on request
	always @(negedge clk) begin
		logic hold;
		if (hold_left != 0) begin
			hold = 1'b1;
			hold_left = hold_left - 1;
		end else if (hold_wanted && !hold_given) begin
			hold = 1'b1;
			hold_given = 1'b1;
			hold_left = 80;
		end else begin
			hold = ($urandom_range(0, 99) < receiver_idle_pct);
		end
		out_stall <= hold;
	end

	// monitor
	always @(posedge clk) begin
		tacs_pkg::result_t got, want;
		tacs_pkg::item_t   taken;
		string             diffs;
		in_taken <= in_valid && !in_stall;
		if (out_valid && !out_stall) begin
			got.action = tacs_pkg::action_t'(action);
			got.tx_frame = tx_frame;
			got.tx_length = tx_length;
			got.crc_on = crc_on;
			got.expected_count = expected_count;
			got.error_code = tacs_pkg::error_t'(error_code);
			got.sak_byte = sak_byte;
			got.uid_part = uid_part;
			got.uid_part_count = uid_part_count;
			got.cascade_level = cascade_level;
			got.iso4_compliant = iso4_compliant;
			if (results_due.size() == 0) begin
				note_fault($sformatf("unexpected result word, action %0d", action));
			end else begin
				want = results_due.pop_front();
				diffs = field_diffs(want, got);
				if (diffs != "")
					note_fault({"result mismatch (expected/actual):", diffs});
			end
		end
		if (in_valid && !in_stall) begin
			taken.kind = kind;
			taken.uid_length = uid_length;
			taken.rx_status = rx_status;
			taken.rx_count = rx_count;
			taken.rx_data = rx_data;
			results_due.push_back(predict_word(taken));
			words_accepted++;
		end
	end

	initial begin
		while (cycles_run < RUN_LIMIT) begin
			@(posedge clk);
			cycles_run++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		int unsigned target;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		write_reg(tacs_pkg::CFG_TAG_MODE, 8'd0);
		write_reg(tacs_pkg::CFG_TAG_VALUE, 8'd0);
		@(posedge clk);

		// directed corner cases
		add_outcome(tacs_pkg::RX_OK, tacs_pkg::ANTI_RX_LEN, 40'd0);
		add_start(4'd0);
		add_start(4'hF);
		add_start(4'd4);
		add_outcome(tacs_pkg::RX_TIMEOUT, 3'd7, 40'hFF_FFFF_FFFF);
		add_outcome(tacs_pkg::RX_TIMEOUT, 3'd0, 40'd0);
		add_reply(32'hFFFF_FFFF);
		add_outcome(tacs_pkg::RX_OK, tacs_pkg::SEL_RX_LEN, 40'h20);
		add_start(4'd7);
		add_reply(32'h0000_0088);
		add_outcome(tacs_pkg::RX_OK, tacs_pkg::SEL_RX_LEN, 40'h04);
		add_reply(32'h0000_0000);
		add_outcome(tacs_pkg::RX_OK, tacs_pkg::SEL_RX_LEN, 40'hFF_FFFF_FFDB);
		add_start(4'd10);
		add_outcome(tacs_pkg::RX_OK, tacs_pkg::ANTI_RX_LEN, 40'hFF_FFFF_FFFF);
		add_start(4'd4);
		add_outcome(tacs_pkg::RX_TIMEOUT, tacs_pkg::ANTI_RX_LEN, 40'd0);
		add_outcome(tacs_pkg::RX_TIMEOUT, tacs_pkg::ANTI_RX_LEN, 40'd0);
		add_outcome(tacs_pkg::RX_TIMEOUT, tacs_pkg::ANTI_RX_LEN, 40'd0);
		add_start(4'd4);
		add_outcome(RX_ERROR, tacs_pkg::ANTI_RX_LEN, 40'd0);
		add_start(4'd10);
		add_outcome(RX_RESERVED, tacs_pkg::ANTI_RX_LEN, 40'd0);
		add_start(4'd4);
		add_reply(32'h0000_0088);
		add_start(4'd7);
		add_reply(32'h0102_0304);
		wait_drained();

		for (int batch = 0; batch < 6; batch++) begin
			case (batch)
				0: begin
					write_reg(tacs_pkg::CFG_TAG_MODE, 8'd0);
					write_reg(tacs_pkg::CFG_TAG_VALUE, 8'hFF);
				end
				1: begin
					write_reg(tacs_pkg::CFG_TAG_MODE, 8'd1);
					write_reg(tacs_pkg::CFG_TAG_VALUE, 8'd0);
				end
				2: begin
					write_reg(tacs_pkg::CFG_TAG_MODE, 8'd1);
					write_reg(tacs_pkg::CFG_TAG_VALUE, 8'hFF);
				end
				3: begin
					write_reg(tacs_pkg::CFG_TAG_MODE, 8'hFF);
					write_reg(tacs_pkg::CFG_TAG_VALUE, 8'd0);
				end
				4: begin
					write_reg(tacs_pkg::CFG_TAG_MODE, 8'd1);
					write_reg(tacs_pkg::CFG_TAG_VALUE, 8'd1);
				end
				default: begin
					write_reg(tacs_pkg::CFG_TAG_MODE, 8'd2);
					write_reg(tacs_pkg::CFG_TAG_VALUE, 8'($urandom));
				end
			endcase
			@(posedge clk);
			if (batch < 2) begin
				sender_idle_pct = 32;
				receiver_idle_pct = 84;
			end else if (batch < 4) begin
				sender_idle_pct = 84;
				receiver_idle_pct = 32;
			end else begin
				sender_idle_pct = 0;
				receiver_idle_pct = 0;
			end
			if (batch == 4)
				hold_wanted = 1'b1;
			target = words_queued + 100;
			while (words_queued < target) begin
				if ($urandom_range(0, 99) < 6)
					add_noise();
				add_session();
			end
			wait_drained();
		end

		repeat (10) @(negedge clk);
		if (results_due.size() != 0)
			note_fault($sformatf("%0d result words never arrived", results_due.size()));
		if (faults == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
